// ===== src/lsg_pkg.sv =====
// shared widths, codes and the classified item type for the led strip gradient unit
`default_nettype none
package lsg_pkg;

    localparam int POS_W   = 10;
    localparam int LEN_W   = 11;
    localparam int SEG_W   = 11;
    localparam int CNT_W   = 4;
    localparam int CH_W    = 8;
    localparam int RGB_W   = 24;
    localparam int PAIR_W  = 48;
    localparam int NPAIRS  = 4;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = CH_W + SEG_W;
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SEG_ZERO = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR_3  = 3'd6;

    typedef enum logic [1:0] {
        KIND_BLACK,
        KIND_SOLID,
        KIND_BLEND
    } kind_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        kind_t            kind;
        logic [1:0]       status;
        logic [SEG_W-1:0] seg;
        logic [CNT_W-1:0] cnt;
    } fe_item_t;

endpackage
`default_nettype wire

// ===== src/led_strip_gradient_color_unit.sv =====
// top level: configuration registers, front end, item queue and back end
// path from input transfer to result valid: front register, item queue, back-end stages, output register
// throughput: one item per cycle while the output is not stalled, set by the pipelined segment and channel dividers
// a 4-entry queue decouples front from back; intake resumes in the cycle after an output stall ends
// reset: asynchronous active low; clears pipeline valids and sets registers to
//        color count 0, continuous mode, strip length 1, all colours black
`default_nettype none
module led_strip_gradient_color_unit
    import lsg_pkg::*;
#(
    parameter int MAX_COLORS = 8,
    parameter int MAX_LEDS   = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [POS_W-1:0]      led_index,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [POS_W-1:0]           led_position,
    output logic [CH_W-1:0]            red_level,
    output logic [CH_W-1:0]            green_level,
    output logic [CH_W-1:0]            blue_level,
    output logic [1:0]                 status,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [PAIR_W-1:0]     cfg_data
);

    logic [CNT_W-1:0]              color_count_reg;
    logic                          gradient_mode_reg;
    logic [LEN_W-1:0]              strip_length_reg;
    logic [NPAIRS-1:0][PAIR_W-1:0] color_pairs_reg;

    logic     q_full;
    logic     q_valid;
    logic     push;
    logic     pop;
    fe_item_t push_item;
    fe_item_t head_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg   <= '0;
            gradient_mode_reg <= 1'b0;
            strip_length_reg  <= LEN_W'(1);
            color_pairs_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COLOR_COUNT:   color_count_reg    <= cfg_data[CNT_W-1:0];
                REG_GRADIENT_MODE: gradient_mode_reg  <= cfg_data[0];
                REG_STRIP_LENGTH:  strip_length_reg   <= cfg_data[LEN_W-1:0];
                REG_COLOR_PAIR_0:  color_pairs_reg[0] <= cfg_data;
                REG_COLOR_PAIR_1:  color_pairs_reg[1] <= cfg_data;
                REG_COLOR_PAIR_2:  color_pairs_reg[2] <= cfg_data;
                REG_COLOR_PAIR_3:  color_pairs_reg[3] <= cfg_data;
                default:           ;
            endcase
        end
    end

    lsg_front #(
        .MAX_COLORS (MAX_COLORS),
        .MAX_LEDS   (MAX_LEDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .led_index     (led_index),
        .color_count   (color_count_reg),
        .gradient_mode (gradient_mode_reg),
        .strip_length  (strip_length_reg),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    lsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    lsg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head_item    (head_item),
        .pop          (pop),
        .color_pairs  (color_pairs_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_position (led_position),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .status       (status)
    );

endmodule
`default_nettype wire

// ===== src/lsg_front.sv =====
// front end: accepts led positions, works out segment length and classifies each item
`default_nettype none
module lsg_front
    import lsg_pkg::*;
#(
    parameter int MAX_COLORS = 8,
    parameter int MAX_LEDS   = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [POS_W-1:0]  led_index,
    input  wire logic [CNT_W-1:0]  color_count,
    input  wire logic              gradient_mode,
    input  wire logic [LEN_W-1:0]  strip_length,
    input  wire logic              q_full,
    output logic                   push,
    output fe_item_t               push_item
);

    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((MAX_LEDS > LEN_MAX) ? LEN_MAX : MAX_LEDS);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_COLORS);

    // ceil(2^16 / d) for the divisors that are not powers of two, exact for 11-bit dividends
    localparam int RECIP_SH = 16;
    localparam int RPROD_W  = LEN_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP_3 = 16'd21846;
    localparam logic [RECIP_SH-1:0] RECIP_5 = 16'd13108;
    localparam logic [RECIP_SH-1:0] RECIP_6 = 16'd10923;
    localparam logic [RECIP_SH-1:0] RECIP_7 = 16'd9363;

    logic [LEN_W-1:0]    len;
    logic [CNT_W-1:0]    cnt;
    logic [LEN_W-1:0]    dividend;
    logic [CNT_W-1:0]    divisor;
    logic [RECIP_SH-1:0] recip;
    logic [RPROD_W-1:0]  recip_prod;
    logic [SEG_W-1:0]    seg;
    fe_item_t            item_next;

    logic             f_valid_reg;
    fe_item_t         f_item_reg;

    always_comb
    begin
        len      = (strip_length > LEN_CAP) ? LEN_CAP : strip_length;
        cnt      = (color_count > CNT_CAP) ? CNT_CAP : color_count;
        dividend = gradient_mode ? len - LEN_W'(1) : len;
        divisor  = gradient_mode ? cnt - CNT_W'(1) : cnt;
        unique case (divisor)
            4'd3:    recip = RECIP_3;
            4'd5:    recip = RECIP_5;
            4'd6:    recip = RECIP_6;
            4'd7:    recip = RECIP_7;
            default: recip = '0;
        endcase
        recip_prod = RPROD_W'(dividend) * RPROD_W'(recip);
        // divisor is a small count: shifts for 1, 2, 4 and 8, reciprocal multiply for 3, 5, 6 and 7, zero otherwise
        unique case (divisor)
            4'd1:    seg = dividend;
            4'd2:    seg = dividend >> 1;
            4'd4:    seg = dividend >> 2;
            4'd8:    seg = dividend >> 3;
            4'd3, 4'd5, 4'd6, 4'd7:
                     seg = recip_prod[RPROD_W-1:RECIP_SH];
            default: seg = '0;
        endcase

        item_next.pos    = led_index;
        item_next.seg    = seg;
        item_next.cnt    = cnt;
        item_next.status = ST_OK;
        item_next.kind   = KIND_BLACK;
        priority if ({1'b0, led_index} >= len)
        begin
            item_next.status = ST_RANGE;
        end
        else if (cnt == '0)
        begin
            item_next.kind = KIND_BLACK;
        end
        else if (cnt == CNT_W'(1))
        begin
            item_next.kind = KIND_SOLID;
        end
        else if (seg == '0)
        begin
            item_next.status = ST_SEG_ZERO;
        end
        else
        begin
            item_next.kind = KIND_BLEND;
        end
    end

    assign in_stall  = f_valid_reg && q_full;
    assign push      = f_valid_reg && !q_full;
    assign push_item = f_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            f_item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/lsg_queue.sv =====
// short fifo of classified items between the front and back ends
`default_nettype none
module lsg_queue
    import lsg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire fe_item_t push_item,
    input  wire logic     pop,
    output logic          q_full,
    output logic          q_valid,
    output fe_item_t      head_item
);

    fe_item_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign q_full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid   = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/lsg_back.sv =====
// back end: pipelined segment divide, colour fetch, channel blend and output register
`default_nettype none
module lsg_back
    import lsg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    input  wire fe_item_t                 head_item,
    output logic                          pop,
    input  wire logic [NPAIRS-1:0][PAIR_W-1:0] color_pairs,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [POS_W-1:0]              led_position,
    output logic [CH_W-1:0]               red_level,
    output logic [CH_W-1:0]               green_level,
    output logic [CH_W-1:0]               blue_level,
    output logic [1:0]                    status
);

    // stage 0 load, POS_W quotient steps, index, colour, multiply, CH_W fraction steps
    localparam int ST_IDX  = POS_W + 1;
    localparam int ST_COL  = POS_W + 2;
    localparam int ST_MUL  = POS_W + 3;
    localparam int ST_FRAC = POS_W + 4;
    localparam int NST     = ST_FRAC + CH_W;

    typedef struct packed {
        fe_item_t                    item;
        logic [SEG_W-1:0]            prem;
        logic [POS_W-1:0]            quo;
        logic [IDX_W-1:0]            ci;
        logic [IDX_W-1:0]            ni;
        logic [2:0][CH_W-1:0]        base;
        logic [2:0]                  neg;
        logic [2:0][CH_W-1:0]        mag;
        logic [2:0][PROD_W-1:0]      num;
        logic [2:0][CH_W-1:0]        frac;
    } pipe_t;

    function automatic logic [RGB_W-1:0] colour_at(
        input logic [NPAIRS-1:0][PAIR_W-1:0] pairs,
        input logic [IDX_W-1:0]              idx
    );
        logic [PAIR_W-1:0] pair;
        pair = pairs[idx[IDX_W-1:1]];
        return idx[0] ? pair[PAIR_W-1:RGB_W] : pair[RGB_W-1:0];
    endfunction

    // a blended position's segment number stays below twice the colour count
    function automatic logic [IDX_W-1:0] quo_mod(
        input logic [POS_W-1:0] q,
        input logic [CNT_W-1:0] c
    );
        logic [POS_W-1:0] r;
        r = (q >= POS_W'(c)) ? q - POS_W'(c) : q;
        return IDX_W'(r);
    endfunction

    pipe_t            stg_reg  [NST];
    pipe_t            stg_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             adv;

    logic             out_valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic [RGB_W-1:0] rgb_reg;
    logic [1:0]       status_reg;
    logic [RGB_W-1:0] rgb_next;

    // the whole back end moves together whenever the output register can take a transfer
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && q_valid;

    always_comb
    begin
        stg_next[0]      = '0;
        stg_next[0].item = head_item;
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_stage
        if (k <= POS_W)
        begin : g_quo
            // restoring divide of position by segment, one quotient bit per stage
            localparam int B = POS_W - k;
            logic [SEG_W:0] trial;
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                trial = {stg_reg[k-1].prem, stg_reg[k-1].item.pos[B]};
                if (trial >= {1'b0, stg_reg[k-1].item.seg})
                begin
                    stg_next[k].prem = SEG_W'(trial - {1'b0, stg_reg[k-1].item.seg});
                    stg_next[k].quo  = {stg_reg[k-1].quo[POS_W-2:0], 1'b1};
                end
                else
                begin
                    stg_next[k].prem = SEG_W'(trial);
                    stg_next[k].quo  = {stg_reg[k-1].quo[POS_W-2:0], 1'b0};
                end
            end
        end
        else if (k == ST_IDX)
        begin : g_idx
            logic [IDX_W-1:0] ci;
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                ci = quo_mod(stg_reg[k-1].quo, stg_reg[k-1].item.cnt);
                stg_next[k].ci = ci;
                stg_next[k].ni = ({1'b0, ci} + CNT_W'(1) == stg_reg[k-1].item.cnt) ?
                                 '0 : ci + IDX_W'(1);
            end
        end
        else if (k == ST_COL)
        begin : g_col
            logic [RGB_W-1:0] c0;
            logic [RGB_W-1:0] c1;
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                c0 = colour_at(color_pairs, stg_reg[k-1].ci);
                c1 = colour_at(color_pairs, stg_reg[k-1].ni);
                for (int ch = 0; ch < 3; ch++)
                begin
                    stg_next[k].base[ch] = c0[ch*CH_W +: CH_W];
                    stg_next[k].neg[ch]  = c1[ch*CH_W +: CH_W] < c0[ch*CH_W +: CH_W];
                    stg_next[k].mag[ch]  = stg_next[k].neg[ch] ?
                        c0[ch*CH_W +: CH_W] - c1[ch*CH_W +: CH_W] :
                        c1[ch*CH_W +: CH_W] - c0[ch*CH_W +: CH_W];
                end
            end
        end
        else if (k == ST_MUL)
        begin : g_mul
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                for (int ch = 0; ch < 3; ch++)
                begin
                    stg_next[k].num[ch] = PROD_W'(stg_reg[k-1].mag[ch]) *
                                          PROD_W'(stg_reg[k-1].prem);
                end
            end
        end
        else
        begin : g_frac
            // |d|*rem / seg, quotient is below 2^CH_W since rem < seg
            localparam int J = NST - 1 - k;
            logic [PROD_W-1:0] sub;
            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                sub = PROD_W'(stg_reg[k-1].item.seg) << J;
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (stg_reg[k-1].num[ch] >= sub)
                    begin
                        stg_next[k].num[ch]  = stg_reg[k-1].num[ch] - sub;
                        stg_next[k].frac[ch] = {stg_reg[k-1].frac[ch][CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        stg_next[k].frac[ch] = {stg_reg[k-1].frac[ch][CH_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_comb
    begin
        rgb_next = '0;
        unique case (stg_reg[NST-1].item.kind)
            KIND_SOLID:
            begin
                rgb_next = colour_at(color_pairs, '0);
            end
            KIND_BLEND:
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    rgb_next[ch*CH_W +: CH_W] = stg_reg[NST-1].neg[ch] ?
                        stg_reg[NST-1].base[ch] - stg_reg[NST-1].frac[ch] :
                        stg_reg[NST-1].base[ch] + stg_reg[NST-1].frac[ch];
                end
            end
            default:
            begin
                rgb_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg    <= stg_reg[NST-1].item.pos;
            rgb_reg    <= rgb_next;
            status_reg <= stg_reg[NST-1].item.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led_position = pos_reg;
    assign red_level    = rgb_reg[3*CH_W-1:2*CH_W];
    assign green_level  = rgb_reg[2*CH_W-1:CH_W];
    assign blue_level   = rgb_reg[CH_W-1:0];
    assign status       = status_reg;

endmodule
`default_nettype wire

// ===== dv/led_strip_gradient_color_unit_tb.sv =====
// self-checking testbench for the led strip gradient color unit
`timescale 1ns / 100ps
module led_strip_gradient_color_unit_tb;
    import lsg_pkg::*;

    localparam int COLOR_SLOTS    = 8;
    localparam int STRIP_CAP      = 1024;
    localparam int PIPE_LATENCY   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int SCRIPT_ROWS    = 44;
    localparam int PAIR_SEL_W     = $clog2(NPAIRS);

    // index past the register file, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [1:0]       st;
    } pixel_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_PIXEL
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] addr;
        logic [PAIR_W-1:0]    data;
        logic [POS_W-1:0]     led;
        logic                 typed;
        logic [RGB_W-1:0]     rgb;
        logic [1:0]           st;
    } script_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [POS_W-1:0]     led_index = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [POS_W-1:0]     led_position;
    logic [CH_W-1:0]      red_level;
    logic [CH_W-1:0]      green_level;
    logic [CH_W-1:0]      blue_level;
    logic [1:0]           status;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAIR_W-1:0]    cfg_data = '0;

    // register copies used by the color predictor
    logic [CNT_W-1:0]     shadow_count = '0;
    logic                 shadow_mode = 1'b0;
    logic [LEN_W-1:0]     shadow_length = 11'd1;
    logic [PAIR_W-1:0]    shadow_pairs [NPAIRS] = '{default: '0};

    pixel_t               expected_pixels [$];
    pixel_t               head_px;
    int unsigned          fault_count = 0;
    int unsigned          quiet_cycles = 0;
    stall_mode_t          stall_mode = STALL_NONE;
    int unsigned          mode_left = 0;
    int unsigned          hold_left = 0;
    script_row_t          script [SCRIPT_ROWS];

    led_strip_gradient_color_unit #(
        .MAX_COLORS (COLOR_SLOTS),
        .MAX_LEDS   (STRIP_CAP)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .led_index    (led_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_position (led_position),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [RGB_W-1:0] palette_color(input logic [IDX_W-1:0] slot);
        logic [PAIR_W-1:0] pair;
        pair = shadow_pairs[slot[IDX_W-1:1]];
        return slot[0] ? pair[PAIR_W-1:RGB_W] : pair[RGB_W-1:0];
    endfunction

    // c0 + ((c1 - c0) * rem) / seg, division truncating toward zero
    function automatic logic [CH_W-1:0] mix_level(input logic [CH_W-1:0] from_lvl,
                                                  input logic [CH_W-1:0] to_lvl,
                                                  input int rem, input int seg);
        int delta;
        int mixed;
        delta = int'(to_lvl) - int'(from_lvl);
        mixed = int'(from_lvl) + (delta * rem) / seg;
        return mixed[CH_W-1:0];
    endfunction

    function automatic pixel_t predict_pixel(input logic [POS_W-1:0] idx);
        pixel_t           px;
        int unsigned      len;
        int unsigned      cnt;
        int unsigned      seg;
        int unsigned      ci;
        int unsigned      ni;
        int unsigned      rem;
        logic [RGB_W-1:0] c0;
        logic [RGB_W-1:0] c1;
        px = '0;
        px.pos = idx;
        px.st = ST_OK;
        len = (shadow_length > STRIP_CAP) ? STRIP_CAP : shadow_length;
        cnt = (shadow_count > COLOR_SLOTS) ? COLOR_SLOTS : shadow_count;
        if (idx >= len)
        begin
            px.st = ST_RANGE;
        end
        else if (cnt == 1)
        begin
            {px.red, px.green, px.blue} = palette_color('0);
        end
        else if (cnt > 1)
        begin
            seg = shadow_mode ? (len - 1) / (cnt - 1) : len / cnt;
            if (seg == 0)
            begin
                px.st = ST_SEG_ZERO;
            end
            else
            begin
                ci = (idx / seg) % cnt;
                ni = (ci + 1) % cnt;
                rem = idx % seg;
                c0 = palette_color(IDX_W'(ci));
                c1 = palette_color(IDX_W'(ni));
                px.red   = mix_level(c0[23:16], c1[23:16], rem, seg);
                px.green = mix_level(c0[15:8], c1[15:8], rem, seg);
                px.blue  = mix_level(c0[7:0], c1[7:0], rem, seg);
            end
        end
        return px;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] addr,
                                            input logic [PAIR_W-1:0] data);
        return '{ROW_WRITE, addr, data, '0, 1'b0, '0, ST_OK};
    endfunction

    function automatic script_row_t pixel_row(input logic [POS_W-1:0] led);
        return '{ROW_PIXEL, '0, '0, led, 1'b0, '0, ST_OK};
    endfunction

    function automatic script_row_t known_row(input logic [POS_W-1:0] led,
                                              input logic [RGB_W-1:0] rgb,
                                              input logic [1:0] st);
        return '{ROW_PIXEL, '0, '0, led, 1'b1, rgb, st};
    endfunction

    // leaves cfg_valid high so back-to-back writes need no second assignment in a step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [PAIR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (addr)
            REG_COLOR_COUNT:   shadow_count = data[CNT_W-1:0];
            REG_GRADIENT_MODE: shadow_mode = data[0];
            REG_STRIP_LENGTH:  shadow_length = data[LEN_W-1:0];
            REG_COLOR_PAIR_0,
            REG_COLOR_PAIR_1,
            REG_COLOR_PAIR_2,
            REG_COLOR_PAIR_3:
                shadow_pairs[PAIR_SEL_W'(addr - REG_COLOR_PAIR_0)] = data;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [POS_W-1:0] idx, input logic typed,
                              input pixel_t want);
        in_valid  <= 1'b1;
        led_index <= idx;
        do @(posedge clk); while (in_stall);
        expected_pixels.push_back(typed ? want : predict_pixel(idx));
    endtask

    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            fault_count++;
        end
    endtask

    function automatic logic [RGB_W-1:0] random_color();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return RGB_W'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t ns: result at position %0d with nothing pending",
                         $time, led_position);
                fault_count++;
            end
            else
            begin
                head_px = expected_pixels.pop_front();
                check_field("led_position", head_px.pos, led_position);
                check_field("red_level", head_px.red, red_level);
                check_field("green_level", head_px.green, green_level);
                check_field("blue_level", head_px.blue, blue_level);
                check_field("status", head_px.st, status);
            end
        end
    end

    // receiver back-pressure, switching pattern every so often
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            default:
            begin
                if (hold_left != 0)
                begin
                    out_stall <= 1'b1;
                    hold_left <= hold_left - 1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    hold_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : 0;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        pixel_t      want;
        int unsigned pixels_sent;
        int unsigned phase_items;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned eff_len;
        int unsigned pick;
        int          r;
        logic        gapless;
        logic [POS_W-1:0]  idx;
        logic [PAIR_W-1:0] data;

        script = '{
            known_row(0, 24'h000000, ST_OK),
            known_row(1, 24'h000000, ST_RANGE),
            known_row(1023, 24'h000000, ST_RANGE),
            reg_row(REG_COLOR_PAIR_0, 48'h000000FFFFFF),
            reg_row(REG_COLOR_COUNT, 48'd1),
            known_row(0, 24'hFFFFFF, ST_OK),
            reg_row(REG_STRIP_LENGTH, 48'd0),
            known_row(0, 24'h000000, ST_RANGE),
            reg_row(REG_STRIP_LENGTH, 48'd2047),
            known_row(1023, 24'hFFFFFF, ST_OK),
            reg_row(REG_COLOR_PAIR_1, 48'h0000FFFF0000),
            reg_row(REG_COLOR_PAIR_2, 48'h80FF7F00FF00),
            reg_row(REG_COLOR_PAIR_3, 48'h123456A5C3E1),
            reg_row(REG_COLOR_COUNT, 48'd15),
            known_row(0, 24'hFFFFFF, ST_OK),
            known_row(128, 24'h000000, ST_OK),
            known_row(256, 24'hFF0000, ST_OK),
            known_row(896, 24'h123456, ST_OK),
            pixel_row(1023),
            pixel_row(64),
            pixel_row(200),
            reg_row(REG_STRIP_LENGTH, 48'd7),
            known_row(3, 24'h000000, ST_SEG_ZERO),
            known_row(7, 24'h000000, ST_RANGE),
            reg_row(REG_GRADIENT_MODE, 48'd1),
            known_row(6, 24'h000000, ST_SEG_ZERO),
            reg_row(REG_STRIP_LENGTH, 48'd8),
            known_row(7, 24'h123456, ST_OK),
            known_row(0, 24'hFFFFFF, ST_OK),
            reg_row(REG_COLOR_COUNT, 48'd3),
            reg_row(REG_STRIP_LENGTH, 48'd1024),
            known_row(1022, 24'hFF0000, ST_OK),
            pixel_row(1023),
            pixel_row(510),
            reg_row(REG_COLOR_COUNT, 48'd2),
            reg_row(REG_GRADIENT_MODE, 48'd0),
            pixel_row(511),
            known_row(512, 24'h000000, ST_OK),
            reg_row(REG_UNUSED, '1),
            pixel_row(700),
            reg_row(REG_COLOR_COUNT, 48'd0),
            known_row(100, 24'h000000, ST_OK),
            reg_row(REG_STRIP_LENGTH, 48'd1025),
            known_row(1023, 24'h000000, ST_OK)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                drain_pixels();
                write_reg(script[i].addr, script[i].data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                want = '{script[i].led, script[i].rgb[23:16], script[i].rgb[15:8],
                         script[i].rgb[7:0], script[i].st};
                send_pixel(script[i].led, script[i].typed, want);
            end
        end

        pixels_sent = 0;
        burst_left = 0;
        while (pixels_sent < RANDOM_ITEMS)
        begin
            // registers only change once every pending pixel has come back
            drain_pixels();
            for (r = REG_COLOR_COUNT; r <= REG_COLOR_PAIR_3; r++)
            begin
                if ($urandom_range(0, 1) == 0)
                    continue;
                case (r)
                    REG_COLOR_COUNT:
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 2)
                            data = PAIR_W'(pick);
                        else if (pick == 2)
                            data = PAIR_W'($urandom_range(9, 15));
                        else
                            data = PAIR_W'($urandom_range(2, 8));
                    end
                    REG_GRADIENT_MODE: data = PAIR_W'($urandom_range(0, 1));
                    REG_STRIP_LENGTH:
                    begin
                        case ($urandom_range(0, 7))
                            0: data = PAIR_W'($urandom_range(0, 2047));
                            1:
                            begin
                                case ($urandom_range(0, 6))
                                    0:       data = 0;
                                    1:       data = 1;
                                    2:       data = 2;
                                    3:       data = 1023;
                                    4:       data = 1024;
                                    5:       data = 1025;
                                    default: data = 2047;
                                endcase
                            end
                            2, 3:    data = PAIR_W'($urandom_range(1, 32));
                            default: data = PAIR_W'($urandom_range(100, 1024));
                        endcase
                    end
                    default: data = {random_color(), random_color()};
                endcase
                write_reg(CFG_IDX_W'(r), data);
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_UNUSED, PAIR_W'({$urandom, $urandom}));

            cfg_valid <= 1'b0;
            eff_len = (shadow_length > STRIP_CAP) ? STRIP_CAP : shadow_length;
            phase_items = $urandom_range(10, 80);
            gapless = ($urandom_range(0, 3) == 0);
            repeat (phase_items)
            begin
                if (!gapless && burst_left == 0)
                begin
                    gap = $urandom_range(1, 8);
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                    burst_left = $urandom_range(1, 16);
                end
                // mostly positions on the strip, some anywhere, some at its end
                pick = $urandom_range(0, 9);
                if (pick == 0 || eff_len == 0)
                    idx = POS_W'($urandom_range(0, 1023));
                else if (pick == 1)
                    idx = (eff_len > 1023) ? 10'd1023
                        : POS_W'($urandom_range(0, 1) ? eff_len : eff_len - 1);
                else
                    idx = POS_W'($urandom_range(0, eff_len - 1));
                send_pixel(idx, 1'b0, '0);
                if (burst_left != 0)
                    burst_left--;
                pixels_sent++;
            end
        end

        drain_pixels();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (fault_count == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lsg_pkg.sv
src/lsg_front.sv
src/lsg_queue.sv
src/lsg_back.sv
src/led_strip_gradient_color_unit.sv
dv/led_strip_gradient_color_unit_tb.sv
